@@ sv/stopwatch_lap_timer_top_defines.svh @@
// Assertion macros shared by the stopwatch lap timer modules.
`ifndef STOPWATCH_LAP_TIMER_TOP_DEFINES_SVH
`define STOPWATCH_LAP_TIMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define SWLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define SWLT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SWLT_ASSERT(lbl, clk, rstn, prop, msg)
`define SWLT_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

@@ sv/swlt_pkg.sv @@
`timescale 1ns / 1ps

package swlt_pkg;

  typedef enum logic [3:0] {
    ModePoll      = 4'd0,
    ModeStartStop = 4'd1,
    ModeStop      = 4'd2,
    ModeReset     = 4'd3,
    ModeLap       = 4'd4,
    ModeLoad      = 4'd5,
    ModeUp        = 4'd6,
    ModeDown      = 4'd7,
    ModeDigit     = 4'd8,
    ModeTenths    = 4'd9,
    ModeEnter     = 4'd10,
    ModeBackspace = 4'd11,
    ModeRead      = 4'd12
  } mode_e;

  localparam logic [31:0] DayMs      = 32'd86400000;
  localparam logic [31:0] HourMs     = 32'd3600000;
  localparam logic [6:0]  LastSlot   = 7'd99;
  localparam logic [3:0]  MaxDigit   = 4'd9;
  localparam logic [3:0]  EntryEmpty = 4'd10;
  localparam logic [3:0]  EntryNone  = 4'd11;

  // Split of the elapsed time, done on the value in tenths of a second.
  localparam int unsigned DivTenthsHour = 36000;
  localparam int unsigned DivTenthsMin  = 600;
  localparam int unsigned DivTenthsSec  = 10;

  // Exact reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k over the
  // full range of x, with k = width(x) + clog2(d).
  localparam int unsigned ShD100  = 39;
  localparam int unsigned ShDHour = 42;
  localparam int unsigned ShDMin  = 26;
  localparam int unsigned ShDSec  = 14;

  localparam logic [32:0] RcpD100 =
    33'(((64'd1 << ShD100) + 64'd99) / 64'd100);
  localparam logic [26:0] RcpDHour =
    27'(((64'd1 << ShDHour) + 64'(DivTenthsHour) - 64'd1) / 64'(DivTenthsHour));
  localparam logic [16:0] RcpDMin =
    17'(((64'd1 << ShDMin) + 64'(DivTenthsMin) - 64'd1) / 64'(DivTenthsMin));
  localparam logic [10:0] RcpDSec =
    11'(((64'd1 << ShDSec) + 64'(DivTenthsSec) - 64'd1) / 64'(DivTenthsSec));

  typedef struct packed {
    logic [3:0]  mode;
    logic [26:0] now_ms;
    logic [3:0]  key_digit;
    logic [31:0] load_ms;
  } item_t;

  // State after one event, handed from the state stage to the formatter.
  typedef struct packed {
    logic [26:0] now_ms;
    logic [26:0] start_ms;
    logic [31:0] accum;
    logic [31:0] lap_total;
    logic [31:0] store_ms;
    logic        running;
    logic        show_tenths;
    logic [6:0]  store_index;
    logic [3:0]  entry_view;
    logic        store_valid;
    logic        lap_taken;
  } core_t;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [31:0] grand_total_ms;
    logic [31:0] div_ms;
    logic [25:0] q100;
    logic [10:0] hours;
    logic [15:0] rem_h;
    logic [5:0]  minutes;
    logic [9:0]  rem_m;
    logic [5:0]  secs;
    logic [3:0]  tenths;
    logic        running;
    logic        show_tenths;
    logic [6:0]  store_index;
    logic [3:0]  entry_view;
    logic        store_valid;
    logic        lap_taken;
  } fmt_t;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [31:0] grand_total_ms;
    logic [10:0] hours;
    logic [5:0]  minutes;
    logic [5:0]  secs;
    logic [3:0]  tenths;
    logic        is_running;
    logic        tenths_shown;
    logic [6:0]  store_index;
    logic [3:0]  entry_view;
    logic        store_valid;
    logic [25:0] store_tenths;
  } res_t;

endpackage

@@ sv/swlt_core.sv @@
`timescale 1ns / 1ps
`include "stopwatch_lap_timer_top_defines.svh"

// Input register plus the stopwatch state update.
module swlt_core import swlt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  up_valid_i,
  output logic  up_ready_o,
  input  item_t up_item_i,
  output logic  dn_valid_o,
  input  logic  dn_ready_i,
  output core_t dn_data_o
);

  logic  a_vld_q, b_vld_q;
  item_t a_q;
  core_t b_q;
  logic  a_adv, b_adv, b_load;

  logic [26:0] start_q, start_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] lap_q, lap_d;
  logic        run_q, run_d;
  logic [6:0]  slot_q, slot_d;
  logic        show_q, show_d;
  logic        idle_q, idle_d;
  logic [3:0]  digit_q, digit_d;

  logic        store;
  logic [31:0] store_ms;
  logic [31:0] fold_add;
  logic [31:0] lap_v;
  logic [31:0] run_gap;
  logic [6:0]  slot_up;

  assign b_adv      = !b_vld_q || dn_ready_i;
  assign a_adv      = !a_vld_q || b_adv;
  assign b_load     = a_vld_q && b_adv;
  assign up_ready_o = a_adv;
  assign dn_valid_o = b_vld_q;
  assign dn_data_o  = b_q;

  assign slot_up = (slot_q >= LastSlot) ? 7'd0 : slot_q + 7'd1;

  always_comb begin
    start_d  = start_q;
    accum_d  = accum_q;
    lap_d    = lap_q;
    run_d    = run_q;
    slot_d   = slot_q;
    show_d   = show_q;
    idle_d   = idle_q;
    digit_d  = digit_q;
    store    = 1'b0;
    store_ms = '0;
    fold_add = '0;

    // Day wrap or a full hour gets folded into the accumulated time first.
    if (run_q) begin
      if (a_q.now_ms < start_q) begin
        fold_add = DayMs - 32'(start_q);
        start_d  = '0;
      end else if (32'(a_q.now_ms) >= 32'(start_q) + HourMs) begin
        fold_add = HourMs;
        start_d  = start_q + 27'(HourMs);
      end
      accum_d = accum_q + fold_add;
      if (lap_q != '0) lap_d = lap_q + fold_add;
    end

    run_gap = 32'(a_q.now_ms) - 32'(start_d);
    lap_v   = run_q ? run_gap + accum_d : accum_d;

    case (mode_e'(a_q.mode))
      ModeStartStop: begin
        if (!run_q) begin
          run_d   = 1'b1;
          start_d = a_q.now_ms;
        end else begin
          accum_d = accum_d + run_gap;
          if (lap_d != '0) lap_d = lap_d + run_gap;
          run_d = 1'b0;
        end
        idle_d = 1'b1;
      end
      ModeStop: begin
        if (run_q) begin
          accum_d = accum_d + run_gap;
          if (lap_d != '0) lap_d = lap_d + run_gap;
          run_d = 1'b0;
        end
      end
      ModeReset: begin
        accum_d = '0;
        lap_d   = '0;
        if (run_q) start_d = a_q.now_ms;
        idle_d = 1'b1;
      end
      ModeLap: begin
        store    = 1'b1;
        store_ms = lap_v;
        slot_d   = slot_up;
        idle_d   = 1'b1;
        if (lap_d != '0) lap_d = lap_d + (lap_v - accum_d);
        else lap_d = lap_v;
        accum_d = '0;
        if (run_q) start_d = a_q.now_ms;
      end
      ModeLoad: begin
        accum_d = a_q.load_ms;
        if (run_q) start_d = a_q.now_ms;
      end
      ModeUp: begin
        slot_d = slot_up;
        idle_d = 1'b1;
      end
      ModeDown: begin
        slot_d = (slot_q == '0) ? LastSlot : slot_q - 7'd1;
        idle_d = 1'b1;
      end
      ModeDigit: begin
        if (a_q.key_digit <= MaxDigit) begin
          if (idle_q || digit_q == EntryEmpty) begin
            digit_d = a_q.key_digit;
            idle_d  = 1'b0;
          end else begin
            slot_d = 7'(7'(digit_q) * 7'd10 + 7'(a_q.key_digit));
            idle_d = 1'b1;
          end
        end
      end
      ModeTenths: show_d = !show_q;
      ModeEnter: begin
        if (idle_q) begin
          store    = 1'b1;
          store_ms = lap_v;
          slot_d   = slot_up;
          idle_d   = 1'b1;
        end else if (digit_q == EntryEmpty) begin
          idle_d = 1'b1;
        end else begin
          slot_d = 7'(digit_q);
          idle_d = 1'b1;
        end
      end
      ModeBackspace: begin
        if (idle_q) begin
          accum_d = '0;
          lap_d   = '0;
          if (run_q) start_d = a_q.now_ms;
          idle_d = 1'b1;
        end else if (digit_q == EntryEmpty) begin
          idle_d = 1'b1;
        end else begin
          digit_d = EntryEmpty;
        end
      end
      ModePoll, ModeRead: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      start_q <= '0;
      accum_q <= '0;
      lap_q   <= '0;
      run_q   <= 1'b0;
      slot_q  <= '0;
      show_q  <= 1'b0;
      idle_q  <= 1'b1;
      digit_q <= EntryEmpty;
    end else begin
      if (a_adv) a_vld_q <= up_valid_i;
      if (b_adv) b_vld_q <= a_vld_q;
      if (b_load) begin
        start_q <= start_d;
        accum_q <= accum_d;
        lap_q   <= lap_d;
        run_q   <= run_d;
        slot_q  <= slot_d;
        show_q  <= show_d;
        idle_q  <= idle_d;
        digit_q <= digit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) a_q <= up_item_i;
    if (b_load) begin
      b_q.now_ms      <= a_q.now_ms;
      b_q.start_ms    <= start_d;
      b_q.accum       <= accum_d;
      b_q.lap_total   <= lap_d;
      b_q.store_ms    <= store_ms;
      b_q.running     <= run_d;
      b_q.show_tenths <= show_d;
      b_q.store_index <= store ? slot_q : slot_d;
      b_q.entry_view  <= idle_d ? EntryNone : digit_d;
      b_q.store_valid <= store;
      b_q.lap_taken   <= (a_q.mode == ModeLap);
    end
  end

  `SWLT_ASSERT(a_slot_range, clk_i, rst_ni, slot_q <= LastSlot, "slot index above 99")
  `SWLT_ASSERT(a_digit_range, clk_i, rst_ni, digit_q <= EntryEmpty, "entry digit out of range")
  `SWLT_ASSERT(a_lap_restart, clk_i, rst_ni, (b_load && (a_q.mode == ModeLap)) |=> ((accum_q == '0) && b_q.store_valid), "lap did not restart")

endmodule

@@ sv/swlt_fmt.sv @@
`timescale 1ns / 1ps
`include "stopwatch_lap_timer_top_defines.svh"

// Elapsed and total times, then the h/m/s/tenths split through
// reciprocal multiplies and remainder steps, spread over the stages.
module swlt_fmt import swlt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  up_valid_i,
  output logic  up_ready_o,
  input  core_t up_data_i,
  output logic  dn_valid_o,
  input  logic  dn_ready_i,
  output res_t  dn_data_o
);

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;
  fmt_t                 st_q [NumStages];
  fmt_t                 st_d [NumStages];

  logic [31:0] v_ms;
  logic [64:0] prod_q100;
  logic [52:0] prod_hour;
  logic [32:0] prod_min;
  logic [20:0] prod_sec;
  logic [25:0] split_sum;

  // Each stage holds while the next one is full and stalled.
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || dn_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign up_ready_o = adv[0];
  assign dn_valid_o = vld_q[NumStages-1];

  always_comb begin
    // Elapsed time and grand total.
    v_ms = up_data_i.running
         ? 32'(up_data_i.now_ms) - 32'(up_data_i.start_ms) + up_data_i.accum
         : up_data_i.accum;
    st_d[0] = '0;
    st_d[0].elapsed_ms     = v_ms;
    st_d[0].grand_total_ms = (up_data_i.lap_total != '0)
                           ? v_ms - up_data_i.accum + up_data_i.lap_total : '0;
    // A stored value goes through the divider; after a lap the split is zero.
    st_d[0].div_ms      = up_data_i.store_valid ? up_data_i.store_ms : v_ms;
    st_d[0].running     = up_data_i.running;
    st_d[0].show_tenths = up_data_i.show_tenths;
    st_d[0].store_index = up_data_i.store_index;
    st_d[0].entry_view  = up_data_i.entry_view;
    st_d[0].store_valid = up_data_i.store_valid;
    st_d[0].lap_taken   = up_data_i.lap_taken;

    // ms -> tenths of a second
    prod_q100    = 65'(st_q[0].div_ms) * 65'(RcpD100);
    st_d[1]      = st_q[0];
    st_d[1].q100 = prod_q100[ShD100 +: 26];

    // hours
    prod_hour     = 53'(st_q[1].q100) * 53'(RcpDHour);
    st_d[2]       = st_q[1];
    st_d[2].hours = prod_hour[ShDHour +: 11];

    // remainder within the hour
    st_d[3]       = st_q[2];
    st_d[3].rem_h = 16'(st_q[2].q100 - 26'(26'(st_q[2].hours) * 26'(DivTenthsHour)));

    // minutes
    prod_min        = 33'(st_q[3].rem_h) * 33'(RcpDMin);
    st_d[4]         = st_q[3];
    st_d[4].minutes = prod_min[ShDMin +: 6];

    // remainder within the minute
    st_d[5]       = st_q[4];
    st_d[5].rem_m = 10'(st_q[4].rem_h - 16'(16'(st_q[4].minutes) * 16'(DivTenthsMin)));

    // seconds and tenths; times ten is a shift-add
    prod_sec       = 21'(st_q[5].rem_m) * 21'(RcpDSec);
    st_d[6]        = st_q[5];
    st_d[6].secs   = prod_sec[ShDSec +: 6];
    st_d[6].tenths = 4'(st_q[5].rem_m - (10'({st_d[6].secs, 3'b000})
                                       + 10'({st_d[6].secs, 1'b0})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= up_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (adv[k]) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    dn_data_o.elapsed_ms     = st_q[NumStages-1].elapsed_ms;
    dn_data_o.grand_total_ms = st_q[NumStages-1].grand_total_ms;
    dn_data_o.hours   = st_q[NumStages-1].lap_taken ? '0 : st_q[NumStages-1].hours;
    dn_data_o.minutes = st_q[NumStages-1].lap_taken ? '0 : st_q[NumStages-1].minutes;
    dn_data_o.secs    = st_q[NumStages-1].lap_taken ? '0 : st_q[NumStages-1].secs;
    dn_data_o.tenths  = st_q[NumStages-1].lap_taken ? '0 : st_q[NumStages-1].tenths;
    dn_data_o.is_running   = st_q[NumStages-1].running;
    dn_data_o.tenths_shown = st_q[NumStages-1].show_tenths;
    dn_data_o.store_index  = st_q[NumStages-1].store_index;
    dn_data_o.entry_view   = st_q[NumStages-1].entry_view;
    dn_data_o.store_valid  = st_q[NumStages-1].store_valid;
    dn_data_o.store_tenths = st_q[NumStages-1].store_valid ? st_q[NumStages-1].q100 : '0;
  end

  // Split recombined; must give back the value in tenths.
  assign split_sum = 26'(st_q[NumStages-1].hours) * 26'(DivTenthsHour)
                   + 26'(st_q[NumStages-1].minutes) * 26'(DivTenthsMin)
                   + 26'(st_q[NumStages-1].secs) * 26'(DivTenthsSec)
                   + 26'(st_q[NumStages-1].tenths);

  `SWLT_ASSERT(a_split_exact, clk_i, rst_ni, vld_q[NumStages-1] |-> (split_sum == st_q[NumStages-1].q100), "time split does not add up")
  `SWLT_ASSERT(a_split_range, clk_i, rst_ni, vld_q[NumStages-1] |-> ((dn_data_o.minutes <= 6'd59) && (dn_data_o.secs <= 6'd59) && (dn_data_o.tenths <= 4'd9)), "split digit out of range")
  // Valid bits are looked at on the edge after a reset edge, once they have cleared.
  `SWLT_ASSERT_NR(a_reset_empty, clk_i, !rst_ni |=> (vld_q == '0), "pipeline not empty in reset")

endmodule

@@ sv/stopwatch_lap_timer_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Width   Contents
// s_axis    in   64/4    event: time of day, digit key, load value; tuser = mode
// m_axis    out  136/1   lap time, grand total, h/m/s/tenths split, flags,
//                        store index, entry view, stored value; tuser = store flag
//
// One event per clock sustained while m_axis_tready is high; the state update (anti-rewind
// fold plus the event's adds) is a registered loop in the state stage.
// m_axis_tvalid is registered through the input register, the state stage and
// seven formatter stages.
// Reset: stopwatch stopped and cleared, index 0, tenths display off, entry idle.
// Every stage has its own valid bit, so bubbles close up under a stalled output
// and s_axis_tready stays high while the input register is free.
module stopwatch_lap_timer_top import swlt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [26:0] now_ms, [30:27] key_digit, [62:31] load_ms, [63] zero
  input  logic [63:0]  s_axis_tdata,
  // [3:0] mode
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] elapsed_ms, [63:32] grand_total_ms, [74:64] hours, [80:75] minutes,
  // [86:81] secs, [90:87] tenths, [91] is_running, [92] tenths_shown,
  // [99:93] store_index, [103:100] entry_view, [129:104] store_tenths,
  // [135:130] zero
  output logic [135:0] m_axis_tdata,
  // [0] store_valid
  output logic [0:0]   m_axis_tuser
);

  item_t in_item;
  logic  core_vld, core_rdy;
  core_t core_data;
  res_t  res;

  assign in_item.mode      = s_axis_tuser;
  assign in_item.now_ms    = s_axis_tdata[26:0];
  assign in_item.key_digit = s_axis_tdata[30:27];
  assign in_item.load_ms   = s_axis_tdata[62:31];

  // Input register and state update.
  swlt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s_axis_tvalid),
    .up_ready_o (s_axis_tready),
    .up_item_i  (in_item),
    .dn_valid_o (core_vld),
    .dn_ready_i (core_rdy),
    .dn_data_o  (core_data)
  );

  // Elapsed/total times and the constant-division split.
  swlt_fmt u_fmt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (core_vld),
    .up_ready_o (core_rdy),
    .up_data_i  (core_data),
    .dn_valid_o (m_axis_tvalid),
    .dn_ready_i (m_axis_tready),
    .dn_data_o  (res)
  );

  assign m_axis_tdata = {6'b000000, res.store_tenths, res.entry_view, res.store_index,
                         res.tenths_shown, res.is_running, res.tenths, res.secs,
                         res.minutes, res.hours, res.grand_total_ms, res.elapsed_ms};
  assign m_axis_tuser = res.store_valid;

endmodule
